// ----- hw/rtl/ptsched_pkg.sv -----
package ptsched_pkg;

    typedef enum logic [3:0] {
        CMD_TICK   = 4'd0,
        CMD_ADMIT  = 4'd1,
        CMD_READY  = 4'd2,
        CMD_SLEEP  = 4'd3,
        CMD_WAKE   = 4'd4,
        CMD_EXIT   = 4'd5,
        CMD_REAP   = 4'd6,
        CMD_SETPRI = 4'd7,
        CMD_PICK   = 4'd8
    } t_cmd;

    typedef enum logic [2:0] {
        SS_FREE   = 3'd0,
        SS_NEW    = 3'd1,
        SS_ASLEEP = 3'd2,
        SS_READY  = 3'd3,
        SS_RUN    = 3'd4,
        SS_DONE   = 3'd5
    } t_slot_state;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_BADPR = 2'd2;
    localparam logic [1:0] ST_WRONG = 2'd3;

    localparam logic [1:0] POL_RR   = 2'd0;
    localparam logic [1:0] POL_FCFS = 2'd1;
    localparam logic [1:0] POL_WRT  = 2'd2;

    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_WHIGH  = 2'd1;
    localparam logic [1:0] REG_WMED   = 2'd2;
    localparam logic [1:0] REG_WLOW   = 2'd3;

    typedef struct packed {
        logic [3:0]  command;
        logic [5:0]  slot;
        logic [15:0] channel;
        logic [1:0]  new_priority;
    } t_item;

    typedef enum logic [2:0] {
        BS_IDLE  = 3'd0,
        BS_LOAD  = 3'd1,
        BS_SCAN  = 3'd2,
        BS_APPLY = 3'd3,
        BS_DONE  = 3'd4,
        BS_CLEAR = 3'd5
    } t_back_state;

endpackage

// ----- hw/rtl/ptsched_front.sv -----
module ptsched_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [3:0]          i_command,
    input  logic [5:0]          i_slot,
    input  logic [15:0]         i_channel,
    input  logic [1:0]          i_new_priority,
    output logic                o_q_valid,
    output ptsched_pkg::t_item  o_q_item,
    input  logic                i_q_pop
);

    // A two-entry queue decouples command capture from execution.
    ptsched_pkg::t_item r_mem [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;
    logic               push;

    assign o_busy    = (r_cnt == 2'd2);
    assign push      = i_start && !o_busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{command: i_command, slot: i_slot,
                             channel: i_channel, new_priority: i_new_priority};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

endmodule

// ----- hw/rtl/ptsched_back.sv -----
module ptsched_back #(
    parameter int TABLE_SLOTS = 64,
    parameter int COUNT_BITS  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  ptsched_pkg::t_item i_q_item,
    output logic               o_q_pop,
    input  logic [1:0]         i_policy,
    input  logic [3:0]         i_weight_high,
    input  logic [3:0]         i_weight_medium,
    input  logic [3:0]         i_weight_low,
    output logic               o_idle,
    output logic               o_result_valid,
    output logic [1:0]         o_status,
    output logic [5:0]         o_chosen_slot,
    output logic [1:0]         o_prev_priority,
    output logic [31:0]        o_wait_ticks,
    output logic [31:0]        o_run_ticks,
    output logic [31:0]        o_sleep_ticks
);

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int PW = (COUNT_BITS + 4 > 32) ? COUNT_BITS + 4 : 32;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam logic [IW-1:0] LAST = IW'(TABLE_SLOTS - 1);

    ptsched_pkg::t_slot_state m_sst [TABLE_SLOTS];
    logic [31:0]              m_arr [TABLE_SLOTS];
    logic [COUNT_BITS-1:0]    m_wc  [TABLE_SLOTS];
    logic [COUNT_BITS-1:0]    m_rc  [TABLE_SLOTS];
    logic [COUNT_BITS-1:0]    m_sc  [TABLE_SLOTS];
    logic [1:0]               m_pri [TABLE_SLOTS];
    logic [15:0]              m_ch  [TABLE_SLOTS];

    ptsched_pkg::t_back_state r_state, n_state;
    ptsched_pkg::t_item       r_item;
    logic [31:0]              r_tick;
    logic [IW-1:0]            r_rot;
    logic [IW-1:0]            r_idx;
    logic                     r_found;
    logic [IW-1:0]            r_best;
    logic [PW-1:0]            r_bkey;
    logic [1:0]               r_status;
    logic [5:0]               r_chosen;
    logic [1:0]               r_oldp;
    logic [31:0]              r_wt, r_rt, r_sl;
    logic                     r_rv;

    // Registered reads of the per-slot stores at the scan index, or at the command's slot outside the scan.
    ptsched_pkg::t_slot_state r_rd_sst;
    logic [31:0]              r_rd_arr;
    logic [COUNT_BITS-1:0]    r_rd_wc, r_rd_rc, r_rd_sc;
    logic [1:0]               r_rd_pri;
    logic [15:0]              r_rd_ch;
    logic [IW-1:0]            r_rd_idx;
    logic                     r_rd_v;
    logic [3:0]               w_sel;
    logic [PW-1:0]            key;
    logic [IW-1:0]            rd_addr;

    logic                     in_range;
    logic [IW-1:0]            sidx;
    ptsched_pkg::t_slot_state sst;
    ptsched_pkg::t_cmd        cmd;
    logic                     scan_cmd;

    assign cmd      = ptsched_pkg::t_cmd'(r_item.command);
    assign in_range = ({26'd0, r_item.slot} < 32'(TABLE_SLOTS));
    assign sidx     = IW'(r_item.slot);
    assign sst      = in_range ? r_rd_sst : ptsched_pkg::SS_FREE;
    assign scan_cmd = (cmd == ptsched_pkg::CMD_TICK) || (cmd == ptsched_pkg::CMD_WAKE) ||
                      (cmd == ptsched_pkg::CMD_PICK) || (cmd == ptsched_pkg::CMD_ADMIT);
    assign rd_addr  = (r_state == ptsched_pkg::BS_SCAN) ? r_idx : sidx;

    always_comb begin
        case (r_rd_pri)
            2'd0:    w_sel = i_weight_high;
            2'd1:    w_sel = i_weight_medium;
            default: w_sel = i_weight_low;
        endcase
        if (i_policy == ptsched_pkg::POL_WRT) begin
            key = PW'(r_rd_rc * w_sel);
        end else begin
            key = PW'(r_rd_arr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_sst <= m_sst[rd_addr];
        r_rd_arr <= m_arr[rd_addr];
        r_rd_wc  <= m_wc[rd_addr];
        r_rd_rc  <= m_rc[rd_addr];
        r_rd_sc  <= m_sc[rd_addr];
        r_rd_pri <= m_pri[rd_addr];
        r_rd_ch  <= m_ch[rd_addr];
        r_rd_idx <= rd_addr;
    end

    assign o_q_pop         = (r_state == ptsched_pkg::BS_IDLE) && i_q_valid;
    assign o_idle          = (r_state == ptsched_pkg::BS_IDLE) && !i_q_valid && !r_rv;
    assign o_result_valid  = r_rv;
    assign o_status        = r_status;
    assign o_chosen_slot   = r_chosen;
    assign o_prev_priority = r_oldp;
    assign o_wait_ticks    = r_wt;
    assign o_run_ticks     = r_rt;
    assign o_sleep_ticks   = r_sl;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptsched_pkg::BS_CLEAR: if (r_idx == LAST) n_state = ptsched_pkg::BS_IDLE;
            ptsched_pkg::BS_IDLE:  if (i_q_valid) n_state = ptsched_pkg::BS_LOAD;
            ptsched_pkg::BS_LOAD:  n_state = scan_cmd ? ptsched_pkg::BS_SCAN
                                                      : ptsched_pkg::BS_APPLY;
            ptsched_pkg::BS_SCAN:  if (r_rd_v && r_rd_idx == LAST)
                                       n_state = ptsched_pkg::BS_APPLY;
            ptsched_pkg::BS_APPLY: n_state = ptsched_pkg::BS_IDLE;
            default:               n_state = ptsched_pkg::BS_IDLE;
        endcase
    end

    function automatic logic [COUNT_BITS-1:0] sat(input logic [COUNT_BITS-1:0] v);
        return (v == CMAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [31:0] clip(input logic [COUNT_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_item <= i_q_item;
        if (!i_rst_n) begin
            r_state <= ptsched_pkg::BS_CLEAR;
            r_tick  <= 32'd0;
            r_rot   <= '0;
            r_rv    <= 1'b0;
            r_idx   <= '0;
            r_rd_v  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rv    <= 1'b0;
            unique case (r_state)
                ptsched_pkg::BS_CLEAR: begin
                    m_sst[r_idx] <= ptsched_pkg::SS_FREE;
                    if (r_idx != LAST) r_idx <= r_idx + 1'b1;
                end
                ptsched_pkg::BS_IDLE: begin
                end
                ptsched_pkg::BS_LOAD: begin
                    r_idx    <= '0;
                    r_rd_v   <= 1'b0;
                    r_found  <= 1'b0;
                    r_best   <= '0;
                    r_bkey   <= '0;
                    r_status <= ptsched_pkg::ST_OK;
                    r_chosen <= r_item.slot;
                    r_oldp   <= 2'd0;
                    r_wt     <= 32'd0;
                    r_rt     <= 32'd0;
                    r_sl     <= 32'd0;
                end
                ptsched_pkg::BS_SCAN: begin
                    if (r_idx != LAST) r_idx <= r_idx + 1'b1;
                    r_rd_v <= 1'b1;
                    if (r_rd_v) begin
                        unique case (cmd)
                            ptsched_pkg::CMD_TICK: begin
                                if (r_rd_sst == ptsched_pkg::SS_READY)
                                    m_wc[r_rd_idx] <= sat(r_rd_wc);
                                else if (r_rd_sst == ptsched_pkg::SS_RUN)
                                    m_rc[r_rd_idx] <= sat(r_rd_rc);
                                else if (r_rd_sst == ptsched_pkg::SS_ASLEEP)
                                    m_sc[r_rd_idx] <= sat(r_rd_sc);
                            end
                            ptsched_pkg::CMD_WAKE: begin
                                if (r_rd_sst == ptsched_pkg::SS_ASLEEP &&
                                    r_rd_ch == r_item.channel) begin
                                    m_sst[r_rd_idx] <= ptsched_pkg::SS_READY;
                                    m_arr[r_rd_idx] <= r_tick;
                                end
                            end
                            ptsched_pkg::CMD_ADMIT: begin
                                if (!r_found && r_rd_sst == ptsched_pkg::SS_FREE) begin
                                    r_found <= 1'b1;
                                    r_best  <= r_rd_idx;
                                end
                            end
                            ptsched_pkg::CMD_PICK: begin
                                if (r_rd_sst == ptsched_pkg::SS_READY) begin
                                    if (i_policy == ptsched_pkg::POL_FCFS ||
                                        i_policy == ptsched_pkg::POL_WRT) begin
                                        if (!r_found || key < r_bkey) begin
                                            r_found <= 1'b1;
                                            r_best  <= r_rd_idx;
                                            r_bkey  <= key;
                                        end
                                    end else begin
                                        // First ready at or after the pointer wins,
                                        // else the first ready below it.
                                        if (!r_found ||
                                            (r_rd_idx >= r_rot && r_best < r_rot)) begin
                                            r_found <= 1'b1;
                                            r_best  <= r_rd_idx;
                                        end
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ptsched_pkg::BS_APPLY: begin
                    r_rv <= 1'b1;
                    case (cmd)
                        ptsched_pkg::CMD_TICK: begin
                            if (r_tick != 32'hFFFF_FFFF) r_tick <= r_tick + 32'd1;
                        end
                        ptsched_pkg::CMD_ADMIT: begin
                            if (r_found) begin
                                m_sst[r_best] <= ptsched_pkg::SS_NEW;
                                m_arr[r_best] <= r_tick;
                                m_wc[r_best]  <= '0;
                                m_rc[r_best]  <= '0;
                                m_sc[r_best]  <= '0;
                                m_pri[r_best] <= 2'd1;
                                m_ch[r_best]  <= 16'd0;
                                r_chosen      <= 6'(r_best);
                            end else begin
                                r_status <= ptsched_pkg::ST_NONE;
                            end
                        end
                        ptsched_pkg::CMD_READY: begin
                            if (in_range && (sst == ptsched_pkg::SS_NEW ||
                                             sst == ptsched_pkg::SS_RUN)) begin
                                m_sst[sidx] <= ptsched_pkg::SS_READY;
                                m_arr[sidx] <= r_tick;
                            end else r_status <= ptsched_pkg::ST_WRONG;
                        end
                        ptsched_pkg::CMD_SLEEP: begin
                            if (in_range && sst == ptsched_pkg::SS_RUN) begin
                                m_sst[sidx] <= ptsched_pkg::SS_ASLEEP;
                                m_ch[sidx]  <= r_item.channel;
                            end else r_status <= ptsched_pkg::ST_WRONG;
                        end
                        ptsched_pkg::CMD_EXIT: begin
                            if (in_range && sst == ptsched_pkg::SS_RUN)
                                m_sst[sidx] <= ptsched_pkg::SS_DONE;
                            else r_status <= ptsched_pkg::ST_WRONG;
                        end
                        ptsched_pkg::CMD_REAP: begin
                            if (in_range && sst == ptsched_pkg::SS_DONE) begin
                                m_sst[sidx] <= ptsched_pkg::SS_FREE;
                                r_wt <= clip(r_rd_wc);
                                r_rt <= clip(r_rd_rc);
                                r_sl <= clip(r_rd_sc);
                            end else r_status <= ptsched_pkg::ST_WRONG;
                        end
                        ptsched_pkg::CMD_SETPRI: begin
                            if (in_range && sst != ptsched_pkg::SS_FREE) begin
                                r_oldp <= r_rd_pri;
                                if (r_item.new_priority == 2'd3)
                                    r_status <= ptsched_pkg::ST_BADPR;
                                else m_pri[sidx] <= r_item.new_priority;
                            end else r_status <= ptsched_pkg::ST_WRONG;
                        end
                        ptsched_pkg::CMD_PICK: begin
                            if (r_found) begin
                                m_sst[r_best] <= ptsched_pkg::SS_RUN;
                                r_rot    <= (r_best == LAST) ? '0 : r_best + 1'b1;
                                r_chosen <= 6'(r_best);
                            end else r_status <= ptsched_pkg::ST_NONE;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/process_table_scheduler_unit.sv -----
// A slot command passes from the idle state through load and apply, and its result
// strobe is registered in apply. Tick, admit, wake and pick first sweep the table one
// slot per cycle through the registered store read port in the scan state. The back
// end takes one item at a time and pops the next only when idle; a two-item command
// queue lets start be taken while the back end works. Synchronous active-low reset
// clears the tick and pointer, then a pass over the table frees every slot; results
// are strobed for one cycle and the receiver cannot stall.
module process_table_scheduler_unit #(
    parameter int TABLE_SLOTS = 64,
    parameter int COUNT_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_command,
    input  logic [5:0]  i_slot,
    input  logic [15:0] i_channel,
    input  logic [1:0]  i_new_priority,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    output logic        o_result_valid,
    output logic [1:0]  o_status,
    output logic [5:0]  o_chosen_slot,
    output logic [1:0]  o_prev_priority,
    output logic [31:0] o_wait_ticks,
    output logic [31:0] o_run_ticks,
    output logic [31:0] o_sleep_ticks
);

    logic               q_valid, q_pop, idle;
    ptsched_pkg::t_item q_item;
    logic [1:0]         r_policy;
    logic [3:0]         r_wh, r_wm, r_wl;

    assign o_cfg_ready = idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 2'd0;
            r_wh     <= 4'd1;
            r_wm     <= 4'd2;
            r_wl     <= 4'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ptsched_pkg::REG_POLICY: r_policy <= i_cfg_data[1:0];
                ptsched_pkg::REG_WHIGH:  r_wh     <= i_cfg_data;
                ptsched_pkg::REG_WMED:   r_wm     <= i_cfg_data;
                ptsched_pkg::REG_WLOW:   r_wl     <= i_cfg_data;
            endcase
        end
    end

    ptsched_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_command      (i_command),
        .i_slot         (i_slot),
        .i_channel      (i_channel),
        .i_new_priority (i_new_priority),
        .o_q_valid      (q_valid),
        .o_q_item       (q_item),
        .i_q_pop        (q_pop)
    );

    ptsched_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_q_pop         (q_pop),
        .i_policy        (r_policy),
        .i_weight_high   (r_wh),
        .i_weight_medium (r_wm),
        .i_weight_low    (r_wl),
        .o_idle          (idle),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_chosen_slot   (o_chosen_slot),
        .o_prev_priority (o_prev_priority),
        .o_wait_ticks    (o_wait_ticks),
        .o_run_ticks     (o_run_ticks),
        .o_sleep_ticks   (o_sleep_ticks)
    );

endmodule
